>>> rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg - shared types for the sorted priority queue
// Command and result beats, cell control and neighbor link structs, codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int FILL_W  = 7;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // command modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] removed;
        logic [FILL_W-1:0]         fill;
    } t_res;

    // broadcast to every cell for one beat
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      gt;
    } t_cell_link;

endpackage : spq_pkg
`default_nettype wire

>>> rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new value or takes the
// left neighbor's entry; on remove it takes the right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  spq_pkg::t_cell_ctrl      i_ctrl,
    input  spq_pkg::t_cell_link      i_left,
    input  spq_pkg::t_cell_link      i_right,
    output spq_pkg::t_cell_link      o_link
);
    import spq_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_gt;

    // empty slots count as greater, so the insert point is the first such cell
    assign w_gt = !r_valid || (r_value > i_ctrl.value);

    assign o_link.valid = r_valid;
    assign o_link.value = r_value;
    assign o_link.gt    = w_gt;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.ins && w_gt) begin
            if (i_left.gt) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.rem) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule : spq_cell
`default_nettype wire

>>> rtl/sorted_array_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit - min-first priority queue
// Sorted row of compare-and-shift cells; insert or remove one entry per beat.
// ----------------------------------------------------------------------------
// usage
//   command channel: a beat is taken on a rising edge with start high and
//   busy low; i_cmd.mode picks insert of i_cmd.value or removal of the
//   smallest entry. busy stays low, so a command can come every cycle.
//   result channel: one beat per command, on o_res for the single cycle
//   in which o_res_strobe is high, in the cycle after the command edge.
//   the receiver cannot stall; results are never held back.
//   config channel: i_cfg_data sets the capacity (reset 64, saturates at
//   DEPTH, zero means always full); o_cfg_ready is always high. write only
//   while no command is in flight.
//   throughput 1 command per cycle, result registered: every cell compares
//   its entry with the new value and shifts in the same cycle, so a beat
//   costs one 32-bit compare plus a neighbor mux in each cell.
//   equal values leave in arrival order; a refused insert changes nothing.
//   reset clears the occupancy and every cell's valid flag; stored values
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit #(
    parameter int DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // command channel
    input  wire                          start,
    output logic                         busy,
    input  spq_pkg::t_cmd                i_cmd,
    // result channel
    output logic                         o_res_strobe,
    output spq_pkg::t_res                o_res,
    // capacity write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [spq_pkg::CAP_W-1:0]    i_cfg_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // occupancy and capacity
    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;
    logic [CAP_W-1:0] r_cap;

    // result register
    logic r_strobe;
    t_res r_res;
    t_res n_res;

    // handshake and decode
    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    int         w_limit;
    t_cell_ctrl w_ctrl;

    // cell row
    t_cell_link w_link [DEPTH];
    logic [DEPTH-1:0] w_valid;
    t_cell_link w_edge;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // capacity above depth saturates
    assign w_limit = (int'(r_cap) < DEPTH) ? int'(r_cap) : DEPTH;
    assign w_full  = int'(r_occ) >= w_limit;
    assign w_empty = (r_occ == '0);

    assign w_ctrl.ins   = w_accept && (i_cmd.mode == MODE_INSERT) && !w_full;
    assign w_ctrl.rem   = w_accept && (i_cmd.mode == MODE_REMOVE) && !w_empty;
    assign w_ctrl.value = i_cmd.value;

    // ends of the row: nothing to the left, an empty slot to the right
    assign w_edge = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  ((gi == 0) ? w_edge : w_link[(gi == 0) ? 0 : gi - 1]),
                .i_right ((gi == DEPTH - 1) ? w_edge
                                            : w_link[(gi == DEPTH - 1) ? gi : gi + 1]),
                .o_link  (w_link[gi])
            );
            assign w_valid[gi] = w_link[gi].valid;
        end
    endgenerate

    // occupancy update
    always_comb begin
        n_occ = r_occ;
        if (w_ctrl.ins) begin
            n_occ = r_occ + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_occ = r_occ - CNT_W'(1);
        end
    end

    // result beat for the accepted command
    always_comb begin
        n_res.status  = STAT_OK;
        n_res.removed = '0;
        n_res.fill    = FILL_W'(n_occ);
        case (i_cmd.mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_res.status = STAT_OVERFLOW;
                end
            end
            MODE_REMOVE: begin
                if (w_empty) begin
                    n_res.status = STAT_UNDERFLOW;
                end else begin
                    // head cell holds the smallest entry
                    n_res.removed = w_link[0].value;
                end
            end
            default: begin
                n_res.status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_cap    <= CAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            r_strobe <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

`ifndef SYNTHESIS
    // every accepted command yields a result beat in the next cycle
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_res_strobe)
        else $error("result beat missing after command");

    // no result beat without a command
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_res_strobe)
        else $error("result beat without command");

    // live cells match the occupancy count
    a_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_occ))
        else $error("cell valid flags disagree with occupancy");

    // live cells are packed at the head of the row
    a_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("gap in the cell row");

    // occupancy never passes the row length
    a_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= DEPTH)
        else $error("occupancy beyond depth");
`endif

endmodule : sorted_array_priority_queue_unit
`default_nettype wire

>>> verif/tb_sorted_array_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue_unit - self-checking bench for the queue
// Drives insert and remove commands through the start/busy channel and
// changes the capacity between phases. A scoreboard keeps its own sorted list
// and checks every result beat (status, removed value, fill) in order.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue_unit;
    import spq_pkg::*;

    localparam int QDEPTH      = 64;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat of any kind
    localparam int DRAIN_WAIT  = 4;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic             busy;
    t_cmd             i_cmd        = '0;
    logic             o_res_strobe;
    t_res             o_res;
    logic             i_cfg_valid  = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data   = '0;

    sorted_array_priority_queue_unit #(
        .DEPTH (QDEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // scoreboard state: the queue contents as the block should hold them
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] model_entries[$];   // kept ascending
    logic [CAP_W-1:0]          capacity_now = CAP_RESET;
    t_res                      result_due_q[$];     // one per accepted command
    t_cmd                      cmd_backlog[$];      // commands not yet driven

    int  fail_count   = 0;
    int  n_cmds       = 0;
    int  n_overflow   = 0;
    int  n_underflow  = 0;
    int  n_removed    = 0;
    int  peak_fill    = 0;
    int  n_cap_writes = 0;
    bit  sender_eager = 1'b0;   // phases with back-to-back commands

    // work out the result of one command and update the list
    task automatic predict_queue_op(input t_cmd c);
        t_res r;
        int   pos;
        int   lim;
        r         = '0;
        r.status  = STAT_OK;
        // capacity above the array depth saturates, zero means always full
        lim = (int'(capacity_now) > QDEPTH) ? QDEPTH : int'(capacity_now);
        if (c.mode == MODE_INSERT) begin
            if (model_entries.size() >= lim) begin
                // refused insert leaves everything as it was
                r.status = STAT_OVERFLOW;
                n_overflow++;
            end else begin
                // new value goes after every entry not greater than it,
                // so equal values leave in arrival order
                pos = model_entries.size();
                while (pos > 0 && $signed(model_entries[pos-1]) > $signed(c.value))
                    pos--;
                model_entries.insert(pos, c.value);
            end
        end else begin
            if (model_entries.size() == 0) begin
                r.status = STAT_UNDERFLOW;
                n_underflow++;
            end else begin
                r.removed = model_entries.pop_front();
                n_removed++;
            end
        end
        r.fill = FILL_W'(model_entries.size());
        if (model_entries.size() > peak_fill)
            peak_fill = model_entries.size();
        result_due_q.push_back(r);
        n_cmds++;
    endtask

    // ------------------------------------------------------------------
    // driver: takes commands from the backlog, random gap (none in eager phases) after each beat
    // ------------------------------------------------------------------
    bit cmd_live = 1'b0;   // mirrors start, updated in this block only
    int gap_cnt  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cmd    <= '0;
            cmd_live = 1'b0;
            gap_cnt  = 0;
        end else begin
            // command beat taken at this edge
            if (start && !busy) begin
                predict_queue_op(i_cmd);
                cmd_live = 1'b0;
                gap_cnt  = sender_eager ? 0 : $urandom_range(0, 19);
            end
            if (!cmd_live && cmd_backlog.size() > 0) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else begin
                    i_cmd    <= cmd_backlog.pop_front();
                    cmd_live = 1'b1;
                end
            end
            // single assignment per edge keeps start high across beats
            start <= cmd_live;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed result is checked against the oldest one due
    // ------------------------------------------------------------------
    t_res res_due;

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe === 1'b1) begin
            if (result_due_q.size() == 0) begin
                $error("result beat with no command outstanding: status %0d removed %0d fill %0d",
                       o_res.status, o_res.removed, o_res.fill);
                fail_count++;
            end else begin
                res_due = result_due_q.pop_front();
                if (o_res.status !== res_due.status) begin
                    $error("status: expected %0d, got %0d", res_due.status, o_res.status);
                    fail_count++;
                end
                if (o_res.removed !== res_due.removed) begin
                    $error("removed: expected %0d, got %0d", res_due.removed, o_res.removed);
                    fail_count++;
                end
                if (o_res.fill !== res_due.fill) begin
                    $error("fill: expected %0d, got %0d", res_due.fill, o_res.fill);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any beat ends the run
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe === 1'b1 || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // values lean on the extremes and on a narrow band to get duplicates
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       pick_value = 32'sh7fff_ffff;
            1:       pick_value = 32'sh8000_0000;
            2, 3, 4: pick_value = VALUE_W'($signed($urandom_range(0, 16)) - 8);
            default: pick_value = $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input logic mode, input logic signed [VALUE_W-1:0] v);
        t_cmd c;
        c.mode  = mode;
        c.value = v;
        cmd_backlog.push_back(c);
    endtask

    // block is idle once every command is driven and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || result_due_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        // beat taken at this edge
        capacity_now = cap;
        n_cap_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // one phase of random commands, insert share in percent
    task automatic run_phase(input int n_items, input int ins_pct, input bit eager);
        int i;
        @(negedge i_clk);
        sender_eager = eager;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(1, 100) <= ins_pct)
                queue_cmd(MODE_INSERT, pick_value());
            else
                queue_cmd(MODE_REMOVE, $urandom);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int p;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: empty removal, extremes, equal values, full drain
        @(negedge i_clk);
        sender_eager = 1'b0;
        queue_cmd(MODE_REMOVE, '0);
        queue_cmd(MODE_INSERT, 32'sd0);
        queue_cmd(MODE_INSERT, 32'sh7fff_ffff);
        queue_cmd(MODE_INSERT, 32'sh8000_0000);
        queue_cmd(MODE_INSERT, -32'sd1);
        queue_cmd(MODE_INSERT, 32'sd1);
        queue_cmd(MODE_INSERT, 32'sd5);
        queue_cmd(MODE_INSERT, 32'sd5);
        queue_cmd(MODE_INSERT, -32'sd1);
        queue_cmd(MODE_REMOVE, 32'sh7fff_ffff);   // value is ignored on removal
        queue_cmd(MODE_REMOVE, '1);
        queue_cmd(MODE_REMOVE, '0);
        queue_cmd(MODE_INSERT, 32'sd0);
        repeat (7) queue_cmd(MODE_REMOVE, '0);
        queue_cmd(MODE_REMOVE, 32'sh8000_0000);   // empty again
        wait_idle();

        // full queue at the reset capacity, then drain to underflow
        write_capacity(7'd64);
        run_phase(300, 75, 1'b0);
        run_phase(200, 25, 1'b1);

        // capacity zero: every insert refused, removals still work
        write_capacity(7'd0);
        run_phase(60, 50, 1'b0);

        // single slot
        write_capacity(7'd1);
        run_phase(150, 50, 1'b1);

        // above the array depth, saturates at 64
        write_capacity(7'd127);
        run_phase(300, 70, 1'b0);

        // lowered below the current fill: inserts refused until drained
        write_capacity(7'd5);
        run_phase(200, 40, 1'b0);

        write_capacity(7'd100);
        run_phase(200, 60, 1'b1);

        // random capacities and mixes
        for (p = 0; p < 6; p++) begin
            write_capacity(7'($urandom_range(0, 127)));
            run_phase($urandom_range(50, 80), $urandom_range(30, 80),
                      1'($urandom_range(0, 1)));
        end

        if (result_due_q.size() != 0) begin
            $error("%0d results never arrived", result_due_q.size());
            fail_count++;
        end

        $display("covered %0d commands over %0d capacity settings, peak fill %0d",
                 n_cmds, n_cap_writes, peak_fill);
        $display("%0d removals, %0d overflows, %0d underflows, %0d mismatches",
                 n_removed, n_overflow, n_underflow, fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule : tb_sorted_array_priority_queue_unit
